### hdl/ultrasonic_echo_range_meter_macros.svh
`ifndef ULTRASONIC_ECHO_RANGE_METER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGE_METER_MACROS_SVH

// same-cycle implication, off during reset
`define UERM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define UERM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/uerm_pkg.sv
package uerm_pkg;

    localparam int STAMP_WIDTH = 16;
    localparam int REG_WIDTH   = 16;
    localparam int TS_WIDTH    = 16;
    localparam int DIST_WIDTH  = 14;
    localparam int CM_WIDTH    = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CALC_W      = (STAMP_WIDTH > REG_WIDTH) ? STAMP_WIDTH : REG_WIDTH;

    localparam logic [REG_WIDTH-1:0] PERIOD_RESET  = REG_WIDTH'(20000);
    localparam logic [REG_WIDTH-1:0] TIMEOUT_RESET = REG_WIDTH'(20000);

    // (10w+29)/58 == (5w+14)/29 ; /29 by reciprocal, shift 29
    localparam int                   MID_W     = REG_WIDTH + 3;
    localparam int                   DIV29_SH  = 29;
    localparam int                   DIV29_MW  = 25;
    localparam logic [DIV29_MW-1:0]  DIV29_MUL = DIV29_MW'(18512791);

    // (d+5)/10 by reciprocal, shift 22
    localparam int                   CMX_W      = DIST_WIDTH + 1;
    localparam int                   DIV10_SH   = 22;
    localparam int                   DIV10_MW   = 19;
    localparam logic [DIV10_MW-1:0]  DIV10_MUL  = DIV10_MW'(419431);
    localparam int                   CMX_PROD_W = CMX_W + DIV10_MW;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMER_PERIOD = 2'd0,
        REG_ECHO_TIMEOUT = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic                  valid;
        logic [DIST_WIDTH-1:0] distance;
    } t_mid;

endpackage

### hdl/uerm_core.sv
module uerm_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic                              i_edge_rising,
    input  logic [uerm_pkg::TS_WIDTH-1:0]     i_timestamp,
    input  logic [uerm_pkg::REG_WIDTH-1:0]    i_timer_period,
    input  logic [uerm_pkg::REG_WIDTH-1:0]    i_echo_timeout,
    input  logic                              i_mid_take,
    output uerm_pkg::t_mid                    o_mid
);

    logic                                r_armed_falling, n_armed_falling;
    logic                                r_measuring,     n_measuring;
    logic                                r_data_ready,    n_data_ready;
    logic [uerm_pkg::STAMP_WIDTH-1:0]    r_rise_stamp,    n_rise_stamp;
    logic [uerm_pkg::STAMP_WIDTH-1:0]    r_fall_stamp,    n_fall_stamp;
    logic [uerm_pkg::DIST_WIDTH-1:0]     r_last_dist,     n_last_dist;
    uerm_pkg::t_mid                      r_mid,           n_mid;

    logic                                accept;
    logic [uerm_pkg::STAMP_WIDTH-1:0]    ts;
    logic [uerm_pkg::STAMP_WIDTH-1:0]    width;
    logic [uerm_pkg::CALC_W-1:0]         width_ext;
    logic [uerm_pkg::CALC_W-1:0]         timeout_ext;
    logic                                width_ok;
    logic [uerm_pkg::MID_W-1:0]          scaled;
    logic [uerm_pkg::MID_W+uerm_pkg::DIV29_MW-1:0] product;
    logic [uerm_pkg::DIST_WIDTH-1:0]     dist_new;

    assign o_stall = r_mid.valid && !i_mid_take;
    assign accept  = i_valid && !o_stall;
    assign ts      = uerm_pkg::STAMP_WIDTH'(i_timestamp);
    assign o_mid   = r_mid;

    always_comb begin
        if (r_fall_stamp >= r_rise_stamp) begin
            width = r_fall_stamp - r_rise_stamp;
        end else begin
            width = uerm_pkg::STAMP_WIDTH'(i_timer_period) - r_rise_stamp + r_fall_stamp;
        end
        width_ext   = uerm_pkg::CALC_W'(width);
        timeout_ext = uerm_pkg::CALC_W'(i_echo_timeout);
        width_ok    = (width_ext != '0) && (width_ext < timeout_ext);
        scaled      = uerm_pkg::MID_W'(width_ext[uerm_pkg::REG_WIDTH-1:0]) * uerm_pkg::MID_W'(5)
                      + uerm_pkg::MID_W'(14);
        product     = (uerm_pkg::MID_W + uerm_pkg::DIV29_MW)'(scaled)
                      * (uerm_pkg::MID_W + uerm_pkg::DIV29_MW)'(uerm_pkg::DIV29_MUL);
        dist_new    = product[uerm_pkg::DIV29_SH +: uerm_pkg::DIST_WIDTH];
    end

    always_comb begin
        n_armed_falling = r_armed_falling;
        n_measuring     = r_measuring;
        n_data_ready    = r_data_ready;
        n_rise_stamp    = r_rise_stamp;
        n_fall_stamp    = r_fall_stamp;
        n_last_dist     = r_last_dist;
        n_mid           = r_mid;
        if (i_mid_take) begin
            n_mid.valid = 1'b0;
        end
        if (accept && !i_kind) begin
            if (!r_armed_falling) begin
                if (i_edge_rising) begin
                    n_rise_stamp    = ts;
                    n_armed_falling = 1'b1;
                end
            end else if (!i_edge_rising) begin
                if (r_measuring) begin
                    n_fall_stamp = ts;
                    n_data_ready = 1'b1;
                    n_measuring  = 1'b0;
                end
                n_armed_falling = 1'b0;
            end
        end else if (accept && i_kind) begin
            if (r_measuring) begin
                n_data_ready    = 1'b0;
                n_armed_falling = 1'b0;
            end else if (r_data_ready) begin
                n_data_ready = 1'b0;
                if (width_ok) begin
                    n_last_dist = dist_new;
                end
            end
            n_measuring    = 1'b1;
            n_mid.valid    = 1'b1;
            n_mid.distance = n_last_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed_falling <= 1'b0;
            r_measuring     <= 1'b0;
            r_data_ready    <= 1'b0;
            r_rise_stamp    <= '0;
            r_fall_stamp    <= '0;
            r_last_dist     <= '0;
            r_mid.valid     <= 1'b0;
        end else begin
            r_armed_falling <= n_armed_falling;
            r_measuring     <= n_measuring;
            r_data_ready    <= n_data_ready;
            r_rise_stamp    <= n_rise_stamp;
            r_fall_stamp    <= n_fall_stamp;
            r_last_dist     <= n_last_dist;
            r_mid.valid     <= n_mid.valid;
        end
        r_mid.distance <= n_mid.distance;
    end

endmodule

### hdl/uerm_out.sv
module uerm_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  uerm_pkg::t_mid                    i_mid,
    output logic                              o_mid_take,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [uerm_pkg::DIST_WIDTH-1:0]   o_distance_tenth_cm,
    output logic [uerm_pkg::CM_WIDTH-1:0]     o_distance_cm
);

    logic                              r_valid, n_valid;
    logic [uerm_pkg::DIST_WIDTH-1:0]   r_tenth, n_tenth;
    logic [uerm_pkg::CM_WIDTH-1:0]     r_cm,    n_cm;
    logic                              advance;
    logic [uerm_pkg::CMX_W-1:0]        rounded;
    logic [uerm_pkg::CMX_PROD_W-1:0]   product;

    assign advance    = !r_valid || !i_stall;
    assign o_mid_take = advance && i_mid.valid;

    always_comb begin
        rounded = uerm_pkg::CMX_W'(i_mid.distance) + uerm_pkg::CMX_W'(5);
        product = uerm_pkg::CMX_PROD_W'(rounded) * uerm_pkg::CMX_PROD_W'(uerm_pkg::DIV10_MUL);
        n_valid = r_valid;
        n_tenth = r_tenth;
        n_cm    = r_cm;
        if (advance) begin
            n_valid = i_mid.valid;
            n_tenth = i_mid.distance;
            n_cm    = product[uerm_pkg::DIV10_SH +: uerm_pkg::CM_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tenth <= n_tenth;
        r_cm    <= n_cm;
    end

    assign o_valid             = r_valid;
    assign o_distance_tenth_cm = r_tenth;
    assign o_distance_cm       = r_cm;

endmodule

### hdl/ultrasonic_echo_range_meter.sv
// channel  direction  handshake                 payload
// input    in         i_valid / o_stall         i_kind, i_edge_rising, i_timestamp
// result   out        o_valid / i_stall         o_distance_tenth_cm, o_distance_cm
// config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while o_stall is low; a tick result is registered in
// the state update and divide by 29 stage, then in the cm rounding stage.
// Edge events give no result. Config writes are always ready.
// Reset is synchronous, active low, and restores 20000 to both registers.
// A stalled result holds; the input stalls only when both stages hold a result.
module ultrasonic_echo_range_meter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic                              i_edge_rising,
    input  logic [uerm_pkg::TS_WIDTH-1:0]     i_timestamp,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [uerm_pkg::DIST_WIDTH-1:0]   o_distance_tenth_cm,
    output logic [uerm_pkg::CM_WIDTH-1:0]     o_distance_cm,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [uerm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [uerm_pkg::REG_WIDTH-1:0]    i_cfg_data
);

    logic [uerm_pkg::REG_WIDTH-1:0] r_timer_period, n_timer_period;
    logic [uerm_pkg::REG_WIDTH-1:0] r_echo_timeout, n_echo_timeout;
    uerm_pkg::t_mid                 mid;
    logic                           mid_take;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_timer_period = r_timer_period;
        n_echo_timeout = r_echo_timeout;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                uerm_pkg::REG_TIMER_PERIOD: n_timer_period = i_cfg_data;
                uerm_pkg::REG_ECHO_TIMEOUT: n_echo_timeout = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_period <= uerm_pkg::PERIOD_RESET;
            r_echo_timeout <= uerm_pkg::TIMEOUT_RESET;
        end else begin
            r_timer_period <= n_timer_period;
            r_echo_timeout <= n_echo_timeout;
        end
    end

    uerm_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_edge_rising  (i_edge_rising),
        .i_timestamp    (i_timestamp),
        .i_timer_period (r_timer_period),
        .i_echo_timeout (r_echo_timeout),
        .i_mid_take     (mid_take),
        .o_mid          (mid)
    );

    uerm_out u_out (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_mid               (mid),
        .o_mid_take          (mid_take),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_distance_tenth_cm (o_distance_tenth_cm),
        .o_distance_cm       (o_distance_cm)
    );

endmodule

### hdl/uerm_checker.sv
`include "ultrasonic_echo_range_meter_macros.svh"

module uerm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic                              i_kind,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [uerm_pkg::DIST_WIDTH-1:0]   o_distance_tenth_cm,
    input  logic [uerm_pkg::CM_WIDTH-1:0]     o_distance_cm
);

    logic [15:0] cm_x10;
    logic [15:0] tenth_r;

    assign cm_x10  = 16'(o_distance_cm) * 16'd10;
    assign tenth_r = 16'(o_distance_tenth_cm) + 16'd5;

    `UERM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_distance_tenth_cm) && $stable(o_distance_cm), "stalled result changed")
    `UERM_ASSERT_NOW(a_cm_round, o_valid, (cm_x10 <= tenth_r) && (tenth_r < cm_x10 + 16'd10), "cm not rounded from tenths")
    `UERM_ASSERT_NOW(a_stall_full, o_stall, o_valid && i_stall, "input stalled with room downstream")
    `UERM_ASSERT_NOW(a_rise_tick, $rose(o_valid), $past(i_valid && !o_stall && i_kind, 2), "result without a tick")

endmodule

bind ultrasonic_echo_range_meter uerm_checker u_uerm_checker (.*);
